[rtl/mbrf_pkg.sv]
// mbrf_pkg: shared sizes, operation codes and beat structs for the multi-byte ring fifo
// no dependencies; imported by every rtl module of the block
`default_nettype none

package mbrf_pkg;

	localparam int LANES = 8;
	localparam int DEPTH = 4096;

	localparam int AW = $clog2(DEPTH);
	localparam int PW = AW + 1;
	localparam int CW = $clog2(LANES + 1);
	// banks: lanes rounded up to a power of two, never more than the store holds
	localparam int NB_RAW = 1 << $clog2(LANES);
	localparam int NB = (NB_RAW < DEPTH) ? NB_RAW : DEPTH;
	localparam int BW = (NB > 1) ? $clog2(NB) : 1;
	localparam int ROWS = DEPTH / NB;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	typedef enum logic {
		OP_PUT = 1'b0,
		OP_GET = 1'b1
	} op_t;

	typedef logic [LANES-1:0][7:0] byte_arr_t;

	typedef struct packed {
		logic       func;
		logic [3:0] request_count;
		logic [7:0] in_byte_0;
		logic [7:0] in_byte_1;
		logic [7:0] in_byte_2;
		logic [7:0] in_byte_3;
		logic [7:0] in_byte_4;
		logic [7:0] in_byte_5;
		logic [7:0] in_byte_6;
		logic [7:0] in_byte_7;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  moved_count;
		logic [7:0]  out_byte_0;
		logic [7:0]  out_byte_1;
		logic [7:0]  out_byte_2;
		logic [7:0]  out_byte_3;
		logic [7:0]  out_byte_4;
		logic [7:0]  out_byte_5;
		logic [7:0]  out_byte_6;
		logic [7:0]  out_byte_7;
		logic [12:0] fill_level;
	} rsp_t;

	// control handed from the pointer logic to every bank lane
	typedef struct packed {
		logic          wr;
		logic          rd;
		logic [AW-1:0] base_addr;
		logic [CW-1:0] count;
	} bank_ctl_t;

endpackage

`default_nettype wire

[rtl/mbrf_lane.sv]
// mbrf_lane: one byte bank of the ring store with its own address and lane decode
// depends on mbrf_pkg
`default_nettype none

module mbrf_lane #(
	parameter int BANK = 0
) (
	input  wire logic                clk,
	input  wire mbrf_pkg::bank_ctl_t ctl,
	input  wire mbrf_pkg::byte_arr_t wr_bytes,
	output logic [7:0]               rd_byte
);
	import mbrf_pkg::*;

	logic [7:0]    mem [ROWS];
	logic [AW-1:0] offs;
	logic [AW-1:0] addr;
	logic [RW-1:0] row;
	logic          hit;
	logic [7:0]    wdata;

	always_comb begin
		// which lane of the beat lands in this bank
		offs = (AW'(BANK) - ctl.base_addr) & AW'(NB - 1);
		addr = ctl.base_addr + offs;
		row = RW'(addr >> BW);
		hit = (offs < AW'(ctl.count)) && (offs < AW'(LANES));
		wdata = '0;
		for (int l = 0; l < LANES; l++) begin
			if (offs == AW'(l)) begin
				wdata = wr_bytes[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.wr && hit) begin
			mem[row] <= wdata;
		end
		if (ctl.rd && hit) begin
			rd_byte <= mem[row];
		end
	end

endmodule

`default_nettype wire

[rtl/mbrf_merge.sv]
// mbrf_merge: rotates registered bank read data back into lane order and blanks unused lanes
// depends on mbrf_pkg
`default_nettype none

module mbrf_merge (
	input  wire logic [mbrf_pkg::NB-1:0][7:0] bank_data,
	input  wire logic [mbrf_pkg::BW-1:0]      first_bank,
	input  wire logic [mbrf_pkg::CW-1:0]      count,
	input  wire logic                         is_get,
	output mbrf_pkg::byte_arr_t               lane_bytes
);
	import mbrf_pkg::*;

	logic [BW-1:0] sel [LANES];

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			sel[i] = BW'((32'(first_bank) + i) % NB);
			if (is_get && (32'(count) > i)) begin
				lane_bytes[i] = bank_data[sel[i]];
			end else begin
				lane_bytes[i] = '0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/multi_byte_ring_fifo_unit.sv]
// multi_byte_ring_fifo_unit: top level of the banked byte ring fifo, pointers and result stage
// depends on mbrf_pkg, mbrf_lane, mbrf_merge
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+------------------------------
//   command   | start, busy (taken if !busy)| req  : cmd_t (put or get)
//   result    | done, one cycle strobe     | rsp  : rsp_t (count, bytes, fill)
//
// a command beat is taken every cycle; its result strobes in the cycle after it is taken
// the store is split in one bank per lane, so all bytes of a beat move in one bank access
// writes and pointer updates land at the accepting edge, so the next beat sees them
// reset clears the pointers and the strobe; the store itself is never cleared
// the receiver cannot stall, so busy never rises
`default_nettype none

module multi_byte_ring_fifo_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire mbrf_pkg::cmd_t req,
	output logic                done,
	output mbrf_pkg::rsp_t      rsp
);
	import mbrf_pkg::*;

	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic          accept;
	logic          is_get;
	logic [PW-1:0] level;
	logic [PW-1:0] space;
	logic [PW-1:0] room;
	logic [CW-1:0] req_sat;
	logic [CW-1:0] room_sat;
	logic [CW-1:0] count;
	logic [PW-1:0] new_level;
	byte_arr_t     wr_bytes;
	bank_ctl_t     ctl;

	logic [NB-1:0][7:0] bank_data;
	byte_arr_t          lane_bytes;

	logic          done_s1;
	logic          get_s1;
	logic [CW-1:0] count_s1;
	logic [BW-1:0] bank_s1;
	logic [PW-1:0] fill_s1;

	assign busy = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		is_get = (req.func == OP_GET);
		level = wp_q - rp_q;
		space = (level <= PW'(DEPTH)) ? PW'(DEPTH) - level : '0;
		room = is_get ? level : space;
		req_sat = (32'(req.request_count) > LANES) ? CW'(LANES) : CW'(req.request_count);
		room_sat = (room < PW'(LANES)) ? CW'(room) : CW'(LANES);
		count = (req_sat < room_sat) ? req_sat : room_sat;
		new_level = is_get ? level - PW'(count) : level + PW'(count);

		wr_bytes = '0;
		wr_bytes[0] = req.in_byte_0;
		wr_bytes[1] = req.in_byte_1;
		wr_bytes[2] = req.in_byte_2;
		wr_bytes[3] = req.in_byte_3;
		wr_bytes[4] = req.in_byte_4;
		wr_bytes[5] = req.in_byte_5;
		wr_bytes[6] = req.in_byte_6;
		wr_bytes[7] = req.in_byte_7;

		ctl.wr = accept && !is_get;
		ctl.rd = accept && is_get;
		ctl.base_addr = is_get ? rp_q[AW-1:0] : wp_q[AW-1:0];
		ctl.count = count;
	end

	for (genvar b = 0; b < NB; b++) begin : g_bank
		mbrf_lane #(
			.BANK(b)
		) u_lane (
			.clk      (clk),
			.ctl      (ctl),
			.wr_bytes (wr_bytes),
			.rd_byte  (bank_data[b])
		);
	end

	mbrf_merge u_merge (
		.bank_data  (bank_data),
		.first_bank (bank_s1),
		.count      (count_s1),
		.is_get     (get_s1),
		.lane_bytes (lane_bytes)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				if (is_get) begin
					rp_q <= rp_q + PW'(count);
				end else begin
					wp_q <= wp_q + PW'(count);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			get_s1 <= is_get;
			count_s1 <= count;
			bank_s1 <= BW'(rp_q[AW-1:0]);
			fill_s1 <= new_level;
		end
	end

	always_comb begin
		done = done_s1;
		rsp.moved_count = 4'(count_s1);
		rsp.out_byte_0 = lane_bytes[0];
		rsp.out_byte_1 = lane_bytes[1];
		rsp.out_byte_2 = lane_bytes[2];
		rsp.out_byte_3 = lane_bytes[3];
		rsp.out_byte_4 = lane_bytes[4];
		rsp.out_byte_5 = lane_bytes[5];
		rsp.out_byte_6 = lane_bytes[6];
		rsp.out_byte_7 = lane_bytes[7];
		rsp.fill_level = 13'(fill_s1);
	end

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat gave no result strobe");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(rsp.moved_count) <= LANES))
		else $error("moved count above lane count");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(wp_q - rp_q) <= PW'(DEPTH))
		else $error("pointer distance above store depth");

	a_idle_lane_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.moved_count == '0) |-> (rsp.out_byte_0 == '0))
		else $error("byte reported on an empty move");
`endif

endmodule

`default_nettype wire

[dv/multi_byte_ring_fifo_unit_test.sv]
// multi_byte_ring_fifo_unit_test: self-checking bench for the multi-byte ring fifo
// predicts each result from a shadow store and pointers, checks every strobed result
// depends on mbrf_pkg and multi_byte_ring_fifo_unit
`default_nettype none

module multi_byte_ring_fifo_unit_test;
	import mbrf_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int TARGET_BEATS = 1450;
	localparam int REPORT_MAX = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t req = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	multi_byte_ring_fifo_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cmd_t pending_cmds[$];
	rsp_t expected_results[$];

	// shadow of the fifo contents and pointers
	logic [7:0] shadow_bytes[DEPTH];
	logic [PW-1:0] shadow_wr_ptr = '0;
	logic [PW-1:0] shadow_rd_ptr = '0;

	int error_count = 0;
	int cycle_count = 0;
	int gen_level = 0;
	bit cmd_taken = 1'b0;
	int idle_left = 0;
	int issued = 0;
	bit burst_mode = 1'b0;

	function automatic byte_arr_t result_lanes(rsp_t r);
		byte_arr_t b;
		b[0] = r.out_byte_0;
		b[1] = r.out_byte_1;
		b[2] = r.out_byte_2;
		b[3] = r.out_byte_3;
		b[4] = r.out_byte_4;
		b[5] = r.out_byte_5;
		b[6] = r.out_byte_6;
		b[7] = r.out_byte_7;
		return b;
	endfunction

	function automatic rsp_t predict_fifo_result(cmd_t c);
		byte_arr_t lane_in;
		byte_arr_t lane_out;
		logic [PW-1:0] lvl;
		int want;
		int room;
		int moved;
		rsp_t r;
		lane_in[0] = c.in_byte_0;
		lane_in[1] = c.in_byte_1;
		lane_in[2] = c.in_byte_2;
		lane_in[3] = c.in_byte_3;
		lane_in[4] = c.in_byte_4;
		lane_in[5] = c.in_byte_5;
		lane_in[6] = c.in_byte_6;
		lane_in[7] = c.in_byte_7;
		lane_out = '0;
		lvl = shadow_wr_ptr - shadow_rd_ptr;
		want = (int'(c.request_count) > LANES) ? LANES : int'(c.request_count);
		if (op_t'(c.func) == OP_PUT) begin
			room = DEPTH - int'(lvl);
			moved = (want < room) ? want : room;
			for (int i = 0; i < moved; i++)
				shadow_bytes[(int'(shadow_wr_ptr) + i) % DEPTH] = lane_in[i];
			shadow_wr_ptr = shadow_wr_ptr + PW'(moved);
		end else begin
			room = int'(lvl);
			moved = (want < room) ? want : room;
			for (int i = 0; i < moved; i++)
				lane_out[i] = shadow_bytes[(int'(shadow_rd_ptr) + i) % DEPTH];
			shadow_rd_ptr = shadow_rd_ptr + PW'(moved);
		end
		r.moved_count = moved[3:0];
		r.out_byte_0 = lane_out[0];
		r.out_byte_1 = lane_out[1];
		r.out_byte_2 = lane_out[2];
		r.out_byte_3 = lane_out[3];
		r.out_byte_4 = lane_out[4];
		r.out_byte_5 = lane_out[5];
		r.out_byte_6 = lane_out[6];
		r.out_byte_7 = lane_out[7];
		r.fill_level = shadow_wr_ptr - shadow_rd_ptr;
		return r;
	endfunction

	task automatic check_result(rsp_t got);
		rsp_t want;
		byte_arr_t want_b;
		byte_arr_t got_b;
		string bad;
		if (expected_results.size() == 0) begin
			error_count++;
			if (error_count <= REPORT_MAX)
				$display("unexpected result: count=%0d bytes=%h fill=%0d",
					got.moved_count, result_lanes(got), got.fill_level);
		end else begin
			want = expected_results.pop_front();
			want_b = result_lanes(want);
			got_b = result_lanes(got);
			bad = "";
			if (got.moved_count !== want.moved_count)
				bad = {bad, " moved_count"};
			for (int i = 0; i < LANES; i++)
				if (got_b[i] !== want_b[i])
					bad = {bad, $sformatf(" out_byte_%0d", i)};
			if (got.fill_level !== want.fill_level)
				bad = {bad, " fill_level"};
			if (bad != "") begin
				error_count++;
				if (error_count <= REPORT_MAX)
					$display("mismatch in%s: expected count=%0d bytes=%h fill=%0d, got count=%0d bytes=%h fill=%0d",
						bad, want.moved_count, want_b, want.fill_level,
						got.moved_count, got_b, got.fill_level);
			end
		end
	endtask

	// queue one beat and track the level the fifo will reach
	task automatic add_cmd(op_t op, int count, byte_arr_t b);
		cmd_t c;
		int want;
		int moved;
		c.func = op;
		c.request_count = count[3:0];
		c.in_byte_0 = b[0];
		c.in_byte_1 = b[1];
		c.in_byte_2 = b[2];
		c.in_byte_3 = b[3];
		c.in_byte_4 = b[4];
		c.in_byte_5 = b[5];
		c.in_byte_6 = b[6];
		c.in_byte_7 = b[7];
		pending_cmds.push_back(c);
		want = (count > LANES) ? LANES : count;
		if (op == OP_PUT) begin
			moved = (want < DEPTH - gen_level) ? want : DEPTH - gen_level;
			gen_level += moved;
		end else begin
			moved = (want < gen_level) ? want : gen_level;
			gen_level -= moved;
		end
	endtask

	function automatic byte_arr_t rand_bytes();
		return {$urandom, $urandom};
	endfunction

	task automatic add_random(int put_pct, int full_pct);
		op_t op;
		int pick;
		int count;
		op = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
		pick = $urandom_range(99);
		if (pick < full_pct)
			count = LANES;
		else if (pick < full_pct + 10)
			count = $urandom_range(15, LANES + 1);
		else
			count = $urandom_range(LANES - 1, 0);
		add_cmd(op, count, rand_bytes());
	endtask

	function automatic int pick_gap();
		int pick;
		pick = $urandom_range(99);
		if (burst_mode || pick < 55)
			return 0;
		else if (pick < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 4);
	endfunction

	// command driver: changes inputs on the falling edge
	always @(negedge clk) begin
		if (arst_n && (!start || cmd_taken)) begin
			if (idle_left > 0) begin
				start <= 1'b0;
				idle_left--;
			end else if (pending_cmds.size() > 0) begin
				req <= pending_cmds.pop_front();
				start <= 1'b1;
				issued++;
				if (issued % 64 == 0)
					burst_mode = ($urandom_range(3) == 0);
				idle_left = pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor and predictor: sample on the rising edge
	always @(posedge clk) begin
		cmd_taken = arst_n && start && !busy;
		if (arst_n && done)
			check_result(rsp);
		if (cmd_taken)
			expected_results.push_back(predict_fifo_result(req));
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		// empty fifo, zero requests, lane saturation, byte extremes
		add_cmd(OP_GET, LANES, rand_bytes());
		add_cmd(OP_GET, 0, rand_bytes());
		add_cmd(OP_PUT, 0, '1);
		add_cmd(OP_PUT, LANES, '0);
		add_cmd(OP_PUT, LANES, '1);
		add_cmd(OP_PUT, 15, rand_bytes());
		add_cmd(OP_PUT, 9, rand_bytes());
		add_cmd(OP_PUT, 1, '1);
		add_cmd(OP_GET, 0, '1);
		add_cmd(OP_GET, 1, rand_bytes());
		add_cmd(OP_GET, 15, rand_bytes());
		add_cmd(OP_GET, LANES, rand_bytes());
		add_cmd(OP_GET, 9, rand_bytes());
		add_cmd(OP_PUT, 5, rand_bytes());
		add_cmd(OP_PUT, 7, rand_bytes());
		add_cmd(OP_PUT, 2, rand_bytes());
		add_cmd(OP_PUT, 4, rand_bytes());
		add_cmd(OP_PUT, 6, rand_bytes());
		add_cmd(OP_GET, 3, rand_bytes());
		add_cmd(OP_GET, 6, rand_bytes());
		add_cmd(OP_GET, 13, rand_bytes());
		add_cmd(OP_GET, LANES, rand_bytes());
		add_cmd(OP_GET, 4, rand_bytes());

		repeat (80) add_random(55, 30);
		// fill to the top, poke it while full, then drain and poke it while empty
		while (gen_level < DEPTH)
			add_random(92, 80);
		repeat (10) add_random(100, 50);
		while (gen_level > 0)
			add_random(8, 80);
		repeat (10) add_random(0, 50);
		while (pending_cmds.size() < TARGET_BEATS)
			add_random(50, 30);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
